// ===== sv/sgl3_pkg.sv =====
// Shared types and constants for the 27-point gradient and Laplacian stencil.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
package sgl3_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int OUT_BITS    = 28;
  localparam int POS_BITS    = 6;
  localparam int SIZE_BITS   = 7;
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);

  localparam logic [SIZE_BITS-1:0] SIZE_MIN = 7'd3;
  localparam logic [SIZE_BITS-1:0] SIZE_MAX = 7'd64;

  // floor(2^36 / 18): reciprocal used for the rounded division by 18.
  localparam logic [31:0] DIV_M = 32'd3817748707;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_SIZE_X     = 2'd0;
  localparam logic [1:0] REG_SIZE_Y     = 2'd1;
  localparam logic [1:0] REG_SIZE_Z     = 2'd2;
  localparam logic [1:0] REG_SOLID_MODE = 2'd3;

  typedef logic [FIFO_PTR_BITS-1:0] fifo_ptr_t;
  typedef logic [FIFO_PTR_BITS:0]   fifo_cnt_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] val;
    logic                          fluid;
  } cell_t;

  typedef cell_t [1:0] pair_t;   // two cells along one axis
  typedef cell_t [2:0] col_t;    // indexed by x offset + 1
  typedef col_t  [1:0] lpair_t;  // two columns along y
  typedef col_t  [2:0] slice_t;  // indexed by y offset + 1
  typedef slice_t [2:0] window_t; // indexed by z offset + 1

  typedef struct packed {
    window_t win;
    logic    last;
  } item_t;

  function automatic logic [SIZE_BITS-1:0] clamp_size(input logic [SIZE_BITS-1:0] v);
    logic [SIZE_BITS-1:0] r;
    r = v;
    if (v < SIZE_MIN) r = SIZE_MIN;
    if (v > SIZE_MAX) r = SIZE_MAX;
    return r;
  endfunction

endpackage

// ===== sv/stencil_gradient_laplacian_3d_core.sv =====
// Top level of the 27-point gradient and Laplacian stencil: configuration registers,
// front end, window queue and arithmetic back end. Depends on sgl3_pkg and all sgl3_ modules.
`timescale 1ns / 1ps
// Usage
//   Samples enter on the s_axis channel in raster order (z fastest, then y, then x),
//   halo layers included: tdata holds the signed Q4.20 sample, tuser the fluid flag.
//   For every site with x, y and z all at least 2, one result leaves on m_axis for the
//   interior site (x-1, y-1, z-1): the three gradient components and the Laplacian in
//   signed Q8.20, tuser is low only for a solid centre in solid-aware mode, and tlast
//   marks the final interior site of the volume.
//   The grid extents and the solid-aware mode are set through the APB port while the
//   block is idle; each extent is clamped to 3..64.
// Timing
//   One sample is taken every cycle while the window queue has room. A result follows the
//   transfer of the sample that completes its window: the store reads are registered, the
//   window is queued, and the differences, sums, division and output are registered in turn.
//   Each store is read and written once per sample, which sets the rate of one per cycle.
// Reset and back-pressure
//   Reset clears the raster position, the queue and all valid flags, and restores the
//   extents to 64 and the mode to fluid-only; the stores need no clearing.
//   When the receiver stalls, the back end holds, the window queue fills and s_axis_tready
//   drops until it drains; no result is lost.
module stencil_gradient_laplacian_3d_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [23:0]  s_axis_tdata,  // [23:0] sample
  input  logic [0:0]   s_axis_tuser,  // [0] is_fluid
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [111:0] m_axis_tdata,  // [27:0] grad_x, [55:28] grad_y, [83:56] grad_z,
                                      // [111:84] laplacian
  output logic [0:0]   m_axis_tuser,  // [0] centre_fluid
  output logic         m_axis_tlast,  // last_site
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  logic [sgl3_pkg::SIZE_BITS-1:0] size_x, size_y, size_z;
  logic                           solid_mode;
  logic                           cfg_wr;

  logic                           push, pop, not_empty, space_ok;
  sgl3_pkg::item_t                push_item, head;
  logic signed [sgl3_pkg::OUT_BITS-1:0] res [4];
  logic                           centre_fluid, last_site;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_x     <= 7'd64;
      size_y     <= 7'd64;
      size_z     <= 7'd64;
      solid_mode <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        sgl3_pkg::REG_SIZE_X:     size_x     <= pwdata[6:0];
        sgl3_pkg::REG_SIZE_Y:     size_y     <= pwdata[6:0];
        sgl3_pkg::REG_SIZE_Z:     size_z     <= pwdata[6:0];
        sgl3_pkg::REG_SOLID_MODE: solid_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      sgl3_pkg::REG_SIZE_X:     prdata = {25'd0, size_x};
      sgl3_pkg::REG_SIZE_Y:     prdata = {25'd0, size_y};
      sgl3_pkg::REG_SIZE_Z:     prdata = {25'd0, size_z};
      sgl3_pkg::REG_SOLID_MODE: prdata = {31'd0, solid_mode};
      default:                  prdata = '0;
    endcase
  end

  sgl3_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_sample (s_axis_tdata),
    .in_fluid  (s_axis_tuser[0]),
    .size_x    (size_x),
    .size_y    (size_y),
    .size_z    (size_z),
    .space_ok  (space_ok),
    .push      (push),
    .push_item (push_item)
  );

  sgl3_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .not_empty (not_empty),
    .head      (head),
    .space_ok  (space_ok)
  );

  sgl3_back u_back (
    .clk          (clk),
    .rst          (rst),
    .solid_mode   (solid_mode),
    .not_empty    (not_empty),
    .head         (head),
    .pop          (pop),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .res          (res),
    .centre_fluid (centre_fluid),
    .last_site    (last_site)
  );

  assign m_axis_tdata = {res[3], res[2], res[1], res[0]};
  assign m_axis_tuser = centre_fluid;
  assign m_axis_tlast = last_site;

endmodule

// ===== sv/sgl3_front.sv =====
// Front end: accepts samples, tracks the raster position and builds the 3x3x3 window
// from a plane store and a line store. Depends on sgl3_pkg.
`timescale 1ns / 1ps
module sgl3_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [sgl3_pkg::SAMPLE_BITS-1:0] in_sample,
  input  logic                                in_fluid,
  input  logic [sgl3_pkg::SIZE_BITS-1:0]      size_x,
  input  logic [sgl3_pkg::SIZE_BITS-1:0]      size_y,
  input  logic [sgl3_pkg::SIZE_BITS-1:0]      size_z,
  input  logic                                space_ok,
  output logic                                push,
  output sgl3_pkg::item_t                     push_item
);

  logic [sgl3_pkg::SIZE_BITS-1:0] sx, sy, sz;
  logic [sgl3_pkg::POS_BITS-1:0]  pos_x, pos_y, pos_z;
  logic                           acc, end_x, end_y, end_z;

  // Stage after acceptance: the read data of both stores arrives here.
  logic                           v1, prod1, last1;
  sgl3_pkg::cell_t                cur1;
  logic [sgl3_pkg::POS_BITS-1:0]  y1, z1;
  sgl3_pkg::pair_t                rdp;
  sgl3_pkg::lpair_t               rdl;
  sgl3_pkg::col_t                 col;
  sgl3_pkg::slice_t               ns, w0, w1;

  // Plane store keeps the two previous x planes per (y, z); line store keeps
  // the two previous y columns per z.
  sgl3_pkg::pair_t                pmem [4096];
  sgl3_pkg::lpair_t               lmem [64];

  assign sx = sgl3_pkg::clamp_size(size_x);
  assign sy = sgl3_pkg::clamp_size(size_y);
  assign sz = sgl3_pkg::clamp_size(size_z);

  assign in_ready = space_ok;
  assign acc      = in_valid && space_ok;
  assign end_x    = ({1'b0, pos_x} + 7'd1) >= sx;
  assign end_y    = ({1'b0, pos_y} + 7'd1) >= sy;
  assign end_z    = ({1'b0, pos_z} + 7'd1) >= sz;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x <= '0;
      pos_y <= '0;
      pos_z <= '0;
      v1    <= 1'b0;
    end else begin
      v1 <= acc;
      if (acc) begin
        if (end_z) begin
          pos_z <= '0;
          if (end_y) begin
            pos_y <= '0;
            pos_x <= end_x ? '0 : pos_x + 6'd1;
          end else begin
            pos_y <= pos_y + 6'd1;
          end
        end else begin
          pos_z <= pos_z + 6'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      cur1.val   <= in_sample;
      cur1.fluid <= in_fluid;
      y1         <= pos_y;
      z1         <= pos_z;
      prod1      <= (pos_x >= 6'd2) && (pos_y >= 6'd2) && (pos_z >= 6'd2);
      last1      <= end_x && end_y && end_z;
      rdp        <= pmem[{pos_y, pos_z}];
      rdl        <= lmem[pos_z];
    end
    if (v1) begin
      pmem[{y1, z1}] <= {cur1, rdp[1]};
      lmem[z1]       <= {col, rdl[1]};
      w0             <= w1;
      w1             <= ns;
    end
  end

  always_comb begin
    col[2] = cur1;
    col[1] = rdp[1];
    col[0] = rdp[0];
    ns[2]  = col;
    ns[1]  = rdl[1];
    ns[0]  = rdl[0];
  end

  assign push           = v1 && prod1;
  assign push_item.win  = {ns, w1, w0};
  assign push_item.last = last1;

endmodule

// ===== sv/sgl3_fifo.sv =====
// Short queue of complete windows between the front end and the arithmetic back end.
// Depends on sgl3_pkg.
`timescale 1ns / 1ps
module sgl3_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  sgl3_pkg::item_t push_item,
  input  logic            pop,
  output logic            not_empty,
  output sgl3_pkg::item_t head,
  output logic            space_ok
);

  sgl3_pkg::item_t     mem [sgl3_pkg::FIFO_DEPTH];
  sgl3_pkg::fifo_ptr_t wr_ptr, rd_ptr;
  sgl3_pkg::fifo_cnt_t count;

  assign not_empty = count != '0;
  assign head      = mem[rd_ptr];
  // Room for the item in the store pipeline and one more accepted now.
  assign space_ok  = count <= sgl3_pkg::fifo_cnt_t'(sgl3_pkg::FIFO_DEPTH - 3);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + sgl3_pkg::fifo_ptr_t'(1);
      if (pop)  rd_ptr <= rd_ptr + sgl3_pkg::fifo_ptr_t'(1);
      count <= count + sgl3_pkg::fifo_cnt_t'(push) - sgl3_pkg::fifo_cnt_t'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_item;
  end

endmodule

// ===== sv/sgl3_back.sv =====
// Back end: differences, partial sums, rounded division by 18 and 9, and the output
// register. Depends on sgl3_pkg.
`timescale 1ns / 1ps
module sgl3_back (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               solid_mode,
  input  logic                               not_empty,
  input  sgl3_pkg::item_t                    head,
  output logic                               pop,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [sgl3_pkg::OUT_BITS-1:0] res [4],
  output logic                               centre_fluid,
  output logic                               last_site
);

  logic adv;
  logic vA, vB, vC, vD, vE;
  logic zA, zB, zC, zD, zE;
  logic lA, lB, lC, lD, lE;

  logic signed [24:0] dA [3][3][3];
  logic signed [28:0] sxB [3], syB [3], szB [3];
  logic signed [30:0] gC [4];
  logic [29:0]        nD [4], nE [4];
  logic               negD [4], negE [4];
  logic [61:0]        prodE [4];

  logic signed [24:0] d_c [3][3][3];
  logic signed [28:0] sx_c [3], sy_c [3], sz_c [3];
  logic signed [30:0] mag_c [4];
  logic [25:0]        q0_c [4];
  logic [30:0]        rem_c [4];
  logic [26:0]        q_c [4];

  assign adv = !out_valid || out_ready;
  assign pop = adv && not_empty;

  // Masked differences against the centre; the centre itself contributes zero.
  always_comb begin
    for (int iz = 0; iz < 3; iz++)
      for (int iy = 0; iy < 3; iy++)
        for (int ix = 0; ix < 3; ix++) begin
          if (solid_mode && !head.win[iz][iy][ix].fluid)
            d_c[iz][iy][ix] = '0;
          else
            d_c[iz][iy][ix] = 25'(head.win[iz][iy][ix].val) - 25'(head.win[1][1][1].val);
        end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      sx_c[a] = '0;
      sy_c[a] = '0;
      sz_c[a] = '0;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) begin
          sx_c[a] = sx_c[a] + 29'(dA[i][j][a]);
          sy_c[a] = sy_c[a] + 29'(dA[i][a][j]);
          sz_c[a] = sz_c[a] + 29'(dA[a][i][j]);
        end
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      mag_c[k] = gC[k][30] ? -gC[k] : gC[k];
      q0_c[k]  = prodE[k][61:36];
      rem_c[k] = {1'b0, nE[k]} - ({5'd0, q0_c[k]} << 4) - ({5'd0, q0_c[k]} << 1);
      q_c[k]   = (rem_c[k] >= 31'd18) ? {1'b0, q0_c[k]} + 27'd1 : {1'b0, q0_c[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vA <= 1'b0;
      vB <= 1'b0;
      vC <= 1'b0;
      vD <= 1'b0;
      vE <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vA <= not_empty;
      vB <= vA;
      vC <= vB;
      vD <= vC;
      vE <= vD;
      out_valid <= vE;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dA <= d_c;
      zA <= solid_mode && !head.win[1][1][1].fluid;
      lA <= head.last;

      sxB <= sx_c;
      syB <= sy_c;
      szB <= sz_c;
      zB  <= zA;
      lB  <= lA;

      gC[0] <= 31'(sxB[2]) - 31'(sxB[0]);
      gC[1] <= 31'(syB[2]) - 31'(syB[0]);
      gC[2] <= 31'(szB[2]) - 31'(szB[0]);
      gC[3] <= 31'(sxB[0]) + 31'(sxB[1]) + 31'(sxB[2]);
      zC    <= zB;
      lC    <= lB;

      // Round to nearest, ties away from zero: floor((|s| + 9) / 18) for the
      // gradient, floor((2|s| + 9) / 18) for the Laplacian.
      for (int k = 0; k < 3; k++) begin
        nD[k]   <= 30'(mag_c[k]) + 30'd9;
        negD[k] <= gC[k][30];
      end
      nD[3]   <= {mag_c[3][28:0], 1'b0} + 30'd9;
      negD[3] <= gC[3][30];
      zD      <= zC;
      lD      <= lC;

      for (int k = 0; k < 4; k++) begin
        prodE[k] <= 62'(nD[k]) * 62'(sgl3_pkg::DIV_M);
        nE[k]    <= nD[k];
        negE[k]  <= negD[k];
      end
      zE <= zD;
      lE <= lD;

      for (int k = 0; k < 4; k++) begin
        if (zE)
          res[k] <= '0;
        else
          res[k] <= negE[k] ? -$signed({1'b0, q_c[k]}) : $signed({1'b0, q_c[k]});
      end
      centre_fluid <= !zE;
      last_site    <= lE;
    end
  end

endmodule

// ===== tb/sv/tb_stencil_gradient_laplacian_3d_core.sv =====
// Self-checking testbench for the 27-point gradient and Laplacian stencil core.
// Streams whole volumes through the block, predicts each result and compares it.
// Depends on sgl3_pkg and stencil_gradient_laplacian_3d_core.
`timescale 1ns / 1ps
module tb_stencil_gradient_laplacian_3d_core;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 40;

  typedef struct {
    logic signed [27:0] gx;
    logic signed [27:0] gy;
    logic signed [27:0] gz;
    logic signed [27:0] lap;
    logic               centre_fluid;
    logic               last_site;
  } grad_result_t;

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [23:0]  s_axis_tdata;   // [23:0] sample
  logic [0:0]   s_axis_tuser;   // [0] is_fluid
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [111:0] m_axis_tdata;   // [27:0] gx, [55:28] gy, [83:56] gz, [111:84] laplacian
  logic [0:0]   m_axis_tuser;   // [0] centre_fluid
  logic         m_axis_tlast;
  logic         psel;
  logic         penable;
  logic         pwrite;
  logic [3:0]   paddr;
  logic [31:0]  pwdata;
  logic [31:0]  prdata;
  logic         pready;

  stencil_gradient_laplacian_3d_core uut (.*);

  // Predictor state: copy of the three-plane ring and the raster position.
  logic signed [23:0] ring_val [0:12287];
  logic               ring_fluid [0:12287];
  int unsigned        cur_x, cur_y, cur_z;
  int unsigned        ext_x, ext_y, ext_z;
  logic               solid_aware;

  grad_result_t expected_q[$];
  int           mismatches;
  int           read_errors;
  int           idle_count;
  bit           rx_stall_on;
  bit           tx_stall_on;

  initial begin
    clk = 1'b0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned clamp_ext(input logic [6:0] v);
    if (v < 7'd3) return 3;
    if (v > 7'd64) return 64;
    return int'(v);
  endfunction

  function automatic logic [13:0] slot_of(input int unsigned x, input int unsigned y,
                                          input int unsigned z);
    return 14'(((x % 3) * 64 + y) * 64 + z);
  endfunction

  function automatic logic signed [27:0] round_sat(input longint s, input longint d);
    longint mag;
    longint q;
    mag = (s < 0) ? -s : s;
    q   = (2 * mag + d) / (2 * d);
    if (s < 0) q = -q;
    if (q > 134217727) q = 134217727;
    if (q < -134217728) q = -134217728;
    return q[27:0];
  endfunction

  // Works out the result, if any, caused by one accepted sample.
  task automatic predict_gradient(input logic [23:0] smp, input logic fl);
    longint       gx;
    longint       gy;
    longint       gz;
    longint       lap;
    longint       d;
    longint       cv;
    logic [13:0]  p;
    bit           solid_centre;
    grad_result_t r;
    gx = 0; gy = 0; gz = 0; lap = 0;
    ring_val[slot_of(cur_x, cur_y, cur_z)]   = smp;
    ring_fluid[slot_of(cur_x, cur_y, cur_z)] = fl;
    if (cur_x >= 2 && cur_y >= 2 && cur_z >= 2) begin
      cv = ring_val[slot_of(cur_x - 1, cur_y - 1, cur_z - 1)];
      solid_centre = solid_aware && !ring_fluid[slot_of(cur_x - 1, cur_y - 1, cur_z - 1)];
      if (!solid_centre) begin
        for (int dx = -1; dx <= 1; dx++)
          for (int dy = -1; dy <= 1; dy++)
            for (int dz = -1; dz <= 1; dz++) begin
              if (dx == 0 && dy == 0 && dz == 0) continue;
              p = slot_of(cur_x - 1 + dx, cur_y - 1 + dy, cur_z - 1 + dz);
              if (solid_aware && !ring_fluid[p]) continue;
              d = longint'(ring_val[p]) - cv;
              gx += dx * d;
              gy += dy * d;
              gz += dz * d;
              lap += d;
            end
      end
      r.gx  = round_sat(gx, 18);
      r.gy  = round_sat(gy, 18);
      r.gz  = round_sat(gz, 18);
      r.lap = round_sat(lap, 9);
      r.centre_fluid = !solid_centre;
      r.last_site = (cur_x + 1 >= ext_x) && (cur_y + 1 >= ext_y) && (cur_z + 1 >= ext_z);
      expected_q.push_back(r);
    end
    if (cur_z + 1 >= ext_z) begin
      cur_z = 0;
      if (cur_y + 1 >= ext_y) begin
        cur_y = 0;
        cur_x = (cur_x + 1 >= ext_x) ? 0 : cur_x + 1;
      end else begin
        cur_y = cur_y + 1;
      end
    end else begin
      cur_z = cur_z + 1;
    end
  endtask

  task automatic send_sample(input logic [23:0] smp, input logic fl);
    if (tx_stall_on) begin
      while ($urandom_range(99) < 35) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= smp;
    s_axis_tuser  <= fl;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_gradient(smp, fl);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      sgl3_pkg::REG_SIZE_X:     ext_x = clamp_ext(val[6:0]);
      sgl3_pkg::REG_SIZE_Y:     ext_y = clamp_ext(val[6:0]);
      sgl3_pkg::REG_SIZE_Z:     ext_z = clamp_ext(val[6:0]);
      sgl3_pkg::REG_SOLID_MODE: solid_aware = val[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input logic [6:0] sx, input logic [6:0] sy, input logic [6:0] sz,
                           input logic mode);
    wait_idle();
    write_reg(sgl3_pkg::REG_SIZE_X, {25'd0, sx});
    write_reg(sgl3_pkg::REG_SIZE_Y, {25'd0, sy});
    write_reg(sgl3_pkg::REG_SIZE_Z, {25'd0, sz});
    write_reg(sgl3_pkg::REG_SOLID_MODE, {31'd0, mode});
  endtask

  // One full volume. kind 0: random, 1: extremes, 2: mostly fluid flags.
  task automatic send_volume(input int kind);
    int n;
    logic [23:0] s;
    logic f;
    n = int'(ext_x * ext_y * ext_z);
    for (int i = 0; i < n; i++) begin
      case (kind)
        1: s = ($urandom_range(1)) ? 24'h7FFFFF : 24'h800000;
        2: s = $urandom_range(3) == 0 ? 24'($urandom) : {{8{1'b0}}, 16'($urandom)};
        default: s = 24'($urandom);
      endcase
      f = (kind == 2) ? ($urandom_range(7) != 0) : 1'($urandom_range(1));
      send_sample(s, f);
    end
  endtask

  task automatic test_smallest_volume();
    configure(7'd3, 7'd3, 7'd3, 1'b0);
    send_volume(0);
  endtask

  task automatic test_saturation();
    configure(7'd4, 7'd3, 7'd3, 1'b0);
    // Both interior centres at the minimum, all other cells at the maximum, then the reverse.
    for (int i = 0; i < 36; i++)
      send_sample((i == 13 || i == 22) ? 24'h800000 : 24'h7FFFFF, 1'b1);
    configure(7'd3, 7'd3, 7'd3, 1'b1);
    for (int i = 0; i < 27; i++)
      send_sample((i == 13) ? 24'h7FFFFF : 24'h800000, 1'b1);
  endtask

  task automatic test_solid_mode();
    configure(7'd3, 7'd4, 7'd3, 1'b1);
    send_volume(2);
    // Solid centre gives a zero result.
    configure(7'd3, 7'd3, 7'd3, 1'b1);
    for (int i = 0; i < 27; i++) send_sample(24'($urandom), i != 13);
  endtask

  task automatic test_clamped_sizes();
    configure(7'd0, 7'd2, 7'd1, 1'b0);
    send_volume(1);
  endtask

  task automatic test_random_volumes();
    int sent;
    sent = 0;
    tx_stall_on = 1'b1;
    rx_stall_on = 1'b1;
    while (sent < 300) begin
      configure(7'($urandom_range(3, 5)), 7'($urandom_range(3, 5)),
                7'($urandom_range(3, 6)), 1'($urandom_range(1)));
      if (sent > 100 && sent < 200) begin
        tx_stall_on = 1'b0;
        rx_stall_on = 1'b0;
      end else begin
        tx_stall_on = 1'b1;
        rx_stall_on = 1'b1;
      end
      send_volume($urandom_range(2) == 1 ? 2 : 0);
      sent += int'(ext_x * ext_y * ext_z);
    end
  endtask

  task automatic test_read_back();
    wait_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {sgl3_pkg::REG_SIZE_Y, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[6:0] !== 7'd64) begin
      $display("%0t: size_y read expected 64 actual %0d", $time, prdata[6:0]);
      read_errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Receiver: random stalls and result checks.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= rx_stall_on ? ($urandom_range(99) >= 35) : 1'b1;
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result actual %h", $time, m_axis_tdata);
          mismatches++;
        end else begin
          grad_result_t e;
          e = expected_q.pop_front();
          if (m_axis_tdata[27:0] !== e.gx || m_axis_tdata[55:28] !== e.gy ||
              m_axis_tdata[83:56] !== e.gz || m_axis_tdata[111:84] !== e.lap ||
              m_axis_tuser[0] !== e.centre_fluid || m_axis_tlast !== e.last_site) begin
            $display("%0t: expected gx %h gy %h gz %h lap %h fl %b last %b", $time,
                     e.gx, e.gy, e.gz, e.lap, e.centre_fluid, e.last_site);
            $display("%0t: actual   gx %h gy %h gz %h lap %h fl %b last %b", $time,
                     m_axis_tdata[27:0], m_axis_tdata[55:28], m_axis_tdata[83:56],
                     m_axis_tdata[111:84], m_axis_tuser[0], m_axis_tlast);
            mismatches++;
          end
        end
      end
    end
  end

  // Watchdog on cycles with no transfer on either stream or the register port.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
      idle_count <= 0;
    else
      idle_count <= idle_count + 1;
    if (idle_count > WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    read_errors = 0;
    rx_stall_on = 1'b0;
    tx_stall_on = 1'b0;
    cur_x = 0; cur_y = 0; cur_z = 0;
    ext_x = 64; ext_y = 64; ext_z = 64;
    solid_aware = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_read_back();
    test_smallest_volume();
    test_saturation();
    test_solid_mode();
    test_clamped_sizes();
    test_random_volumes();
    wait_idle();
    if (mismatches == 0 && read_errors == 0 && expected_q.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== files.f =====
sv/sgl3_pkg.sv
sv/sgl3_front.sv
sv/sgl3_fifo.sv
sv/sgl3_back.sv
sv/stencil_gradient_laplacian_3d_core.sv
tb/sv/tb_stencil_gradient_laplacian_3d_core.sv
